>>> src/assert_macros.svh
// Assertion macros shared by the scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSRS_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSRS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tsrs_pkg.sv
// Shared types, constants and register map for the two-slot rational scaler.
`timescale 1ns / 1ps

package tsrs_pkg;

    localparam int MAX_CODES  = 4;
    localparam int CODE_W     = 16;
    localparam int CODE_CNT_W = 3;
    localparam int VAL_W      = 16;
    localparam int COEF_W     = 32;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int REG_IDX_W  = 3;
    localparam int DIV_STEPS  = VAL_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [7:0] MATCH_TYPE_RESET = 8'd2;

    // Register indexes; byte address is 8 * index.
    localparam logic [REG_IDX_W-1:0] REG_MATCH_TYPE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_SLOT0    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_SLOT1    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FALLBACK_SLOT0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FALLBACK_SLOT1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CODE_COUNT    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CODE_LIST     = 3'd6;

    typedef struct packed {
        logic [7:0]              event_type;
        logic [CODE_W-1:0]       event_code;
        logic signed [VAL_W-1:0] event_value;
        logic                    current_slot;
        logic                    use_remainder;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    was_scaled;
    } out_item_t;

    typedef struct packed {
        logic [7:0]                  match_type;
        logic [COEF_W-1:0]           coef_slot_zero;
        logic [COEF_W-1:0]           coef_slot_one;
        logic [COEF_W-1:0]           fallback_slot_zero;
        logic [COEF_W-1:0]           fallback_slot_one;
        logic [CODE_CNT_W-1:0]       code_count;
        logic [MAX_CODES*CODE_W-1:0] code_list;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend_mag;
        logic [VAL_W-1:0] divisor_mag;
        logic             neg_quo;
        logic             neg_rem;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAL_W-1:0] quotient;
        logic [VAL_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> src/tsrs_in_if.sv
// Valid/ready channel that carries one input event.
`timescale 1ns / 1ps

interface tsrs_in_if;
    logic               valid;
    logic               ready;
    tsrs_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> src/tsrs_out_if.sv
// Valid/ready channel that carries one scaled result.
`timescale 1ns / 1ps

interface tsrs_out_if;
    logic                valid;
    logic                ready;
    tsrs_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> src/tsrs_cfg_regs.sv
// APB-style configuration register file for the scaler.
`timescale 1ns / 1ps

module tsrs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsrs_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsrs_pkg::DATA_W-1:0]   pwdata,
    output logic [tsrs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tsrs_pkg::cfg_t                cfg
);

    localparam int IdxW = tsrs_pkg::REG_IDX_W;

    tsrs_pkg::cfg_t        cfg_reg;
    logic                  wr_en;
    logic [IdxW-1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[tsrs_pkg::ADDR_W-1 -: IdxW];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg            <= '0;
            cfg_reg.match_type <= tsrs_pkg::MATCH_TYPE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tsrs_pkg::REG_MATCH_TYPE:     cfg_reg.match_type <= pwdata[7:0];
                tsrs_pkg::REG_COEF_SLOT0:     cfg_reg.coef_slot_zero <= pwdata[31:0];
                tsrs_pkg::REG_COEF_SLOT1:     cfg_reg.coef_slot_one <= pwdata[31:0];
                tsrs_pkg::REG_FALLBACK_SLOT0: cfg_reg.fallback_slot_zero <= pwdata[31:0];
                tsrs_pkg::REG_FALLBACK_SLOT1: cfg_reg.fallback_slot_one <= pwdata[31:0];
                tsrs_pkg::REG_CODE_COUNT:
                    cfg_reg.code_count <= pwdata[tsrs_pkg::CODE_CNT_W-1:0];
                tsrs_pkg::REG_CODE_LIST:      cfg_reg.code_list <= pwdata;
                default: ;  // unmapped: drop the write
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            tsrs_pkg::REG_MATCH_TYPE:     prdata = 64'(cfg_reg.match_type);
            tsrs_pkg::REG_COEF_SLOT0:     prdata = 64'(cfg_reg.coef_slot_zero);
            tsrs_pkg::REG_COEF_SLOT1:     prdata = 64'(cfg_reg.coef_slot_one);
            tsrs_pkg::REG_FALLBACK_SLOT0: prdata = 64'(cfg_reg.fallback_slot_zero);
            tsrs_pkg::REG_FALLBACK_SLOT1: prdata = 64'(cfg_reg.fallback_slot_one);
            tsrs_pkg::REG_CODE_COUNT:     prdata = 64'(cfg_reg.code_count);
            tsrs_pkg::REG_CODE_LIST:      prdata = cfg_reg.code_list;
            default:                      prdata = '0;
        endcase
    end

endmodule

>>> src/tsrs_div_unit.sv
// Radix-2 restoring divider on magnitudes with a shared 17-bit subtractor.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsrs_div_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsrs_pkg::div_req_t   req,
    output tsrs_pkg::div_rsp_t   rsp
);

    localparam int W    = tsrs_pkg::VAL_W;
    localparam int CntW = tsrs_pkg::DIV_CNT_W;

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_FIX  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [CntW-1:0] cnt_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    quo_reg;
    logic [W-1:0]    dsr_reg;
    logic            neg_quo_reg;
    logic            neg_rem_reg;
    logic [W:0]      trial;

    // Shift in the next dividend bit and try the subtract.
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (req.start) state_next = DV_RUN;
            DV_RUN:  if (cnt_reg == CntW'(tsrs_pkg::DIV_STEPS - 1)) state_next = DV_FIX;
            DV_FIX:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DV_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend_mag;
            dsr_reg     <= req.divisor_mag;
            neg_quo_reg <= req.neg_quo;
            neg_rem_reg <= req.neg_rem;
        end
        else if (state_reg == DV_RUN)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    // Apply signs: quotient truncates toward zero, remainder follows the dividend.
    assign rsp.busy      = (state_reg != DV_IDLE);
    assign rsp.done      = (state_reg == DV_FIX);
    assign rsp.quotient  = neg_quo_reg ? (W'(0) - quo_reg) : quo_reg;
    assign rsp.remainder = neg_rem_reg ? (W'(0) - rem_reg) : rem_reg;

    `TSRS_ASSERT_NEXT(a_div_start_runs, clk, rst_n, (state_reg == DV_IDLE) && req.start,
        state_reg == DV_RUN, "divider did not start")
    `TSRS_ASSERT_NEXT(a_div_done_pulse, clk, rst_n, rsp.done, !rsp.done,
        "divider done held longer than one cycle")
    `TSRS_ASSERT_NOW(a_div_rem_below_divisor, clk, rst_n, rsp.done,
        rem_reg < dsr_reg, "divider remainder not below divisor")

endmodule

>>> src/two_slot_rational_scaler.sv
// Two-slot rational scaler: event matching, sequencer and result register.
//
// Usage:
//   Input events arrive on in_ch (valid/ready); each transfer carries type, code,
//   signed value, slot select and the remainder-carry enable. One result per
//   event leaves on out_ch (valid/ready) with the output value and a scaled flag.
//   Registers are written over the APB-style port (8-byte stride, pready high).
//   A scaled event passes the states S_MUL, S_ADD, S_DIV and S_OUT before its
//   result is loaded; a passed-through event (no type/code match or zero divisor)
//   goes from S_MUL straight to S_OUT. One event is worked on at a time; in_ch is
//   ready again once the result is loaded into the output register. S_DIV waits on
//   the 16-step restoring divider, which yields one quotient bit a cycle.
//   Reset clears the remainder carry, the sequencer and the output valid flag and
//   loads the register defaults (match type 2, everything else zero).
//   When the receiver stalls, the finished result holds in the output register;
//   one more event may be taken and worked on, then the sequencer waits for the
//   output register to free before loading it, and in_ch stays low meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_slot_rational_scaler (
    input  logic                         clk,
    input  logic                         rst_n,
    tsrs_in_if.sink                      in_ch,
    tsrs_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tsrs_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsrs_pkg::DATA_W-1:0]  pwdata,
    output logic [tsrs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int W     = tsrs_pkg::VAL_W;
    localparam int CntW  = tsrs_pkg::CODE_CNT_W;
    localparam int CodeW = tsrs_pkg::CODE_W;
    localparam int NCode = tsrs_pkg::MAX_CODES;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    tsrs_pkg::cfg_t      cfg;
    tsrs_pkg::div_req_t  div_req;
    tsrs_pkg::div_rsp_t  div_rsp;

    logic [2:0]          state_reg, state_next;
    tsrs_pkg::in_item_t  item_reg;
    logic [W-1:0]        prod_reg;
    logic [W-1:0]        divisor_reg;
    logic [W-1:0]        carry_reg;
    logic [W-1:0]        res_value_reg;
    logic                res_scaled_reg;
    logic                out_valid_reg;
    tsrs_pkg::out_item_t out_item_reg;

    logic [CntW-1:0]     code_lim;
    logic                code_hit;
    logic                type_hit;
    logic [31:0]         packed_sel;
    logic [31:0]         packed_coef;
    logic [W-1:0]        mul_val;
    logic [2*W-1:0]      prod_full;
    logic [W-1:0]        sum;
    logic                in_xfer;
    logic                out_xfer;
    logic                out_free;

    tsrs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsrs_div_unit u_div_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;
    assign out_xfer     = out_valid_reg && out_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;

    // Match the event code against the first code_count codes (capped at the list size).
    always_comb
    begin
        code_lim = (cfg.code_count > CntW'(NCode)) ? CntW'(NCode) : cfg.code_count;
        code_hit = 1'b0;
        for (int i = 0; i < NCode; i++)
        begin
            if ((CntW'(i) < code_lim) &&
                (cfg.code_list[i*CodeW +: CodeW] == item_reg.event_code))
            begin
                code_hit = 1'b1;
            end
        end
    end

    assign type_hit    = (item_reg.event_type == cfg.match_type);
    assign packed_sel  = item_reg.current_slot ? cfg.coef_slot_one : cfg.coef_slot_zero;
    assign packed_coef = (packed_sel != '0) ? packed_sel :
                         (item_reg.current_slot ? cfg.fallback_slot_one
                                                : cfg.fallback_slot_zero);
    assign mul_val     = packed_coef[2*W-1:W];
    // Only the low half of the product survives the 16-bit wrap.
    assign prod_full   = {{W{1'b0}}, item_reg.event_value} * {{W{1'b0}}, mul_val};
    assign sum         = prod_reg + (item_reg.use_remainder ? carry_reg : W'(0));

    always_comb
    begin
        div_req.start        = (state_reg == S_ADD);
        div_req.dividend_mag = sum[W-1] ? (W'(0) - sum) : sum;
        div_req.divisor_mag  = divisor_reg[W-1] ? (W'(0) - divisor_reg) : divisor_reg;
        div_req.neg_quo      = sum[W-1] ^ divisor_reg[W-1];
        div_req.neg_rem      = sum[W-1];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_MUL;
            S_MUL:
            begin
                if (type_hit && code_hit && (packed_coef[W-1:0] != '0))
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_ADD:  state_next = S_DIV;
            S_DIV:  if (div_rsp.done) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            carry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIV && div_rsp.done && item_reg.use_remainder)
            begin
                carry_reg <= div_rsp.remainder;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_ch.item;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg       <= prod_full[W-1:0];
            divisor_reg    <= packed_coef[W-1:0];
            // Pass-through result; overwritten below when the event is scaled.
            res_value_reg  <= item_reg.event_value;
            res_scaled_reg <= 1'b0;
        end
        else if (state_reg == S_DIV && div_rsp.done)
        begin
            res_value_reg  <= div_rsp.quotient;
            res_scaled_reg <= 1'b1;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_item_reg.out_value  <= res_value_reg;
            out_item_reg.was_scaled <= res_scaled_reg;
        end
    end

    `TSRS_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, in_xfer,
        (state_reg == S_MUL) && !in_ch.ready, "accepted event did not start work")
    `TSRS_ASSERT_NOW(a_start_only_idle_div, clk, rst_n, div_req.start,
        !div_rsp.busy, "divider started while busy")
    `TSRS_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_OUT) && out_free,
        out_valid_reg && (state_reg == S_IDLE), "result not loaded into output register")
    `TSRS_ASSERT_NEXT(a_carry_only_on_done, clk, rst_n,
        !((state_reg == S_DIV) && div_rsp.done && item_reg.use_remainder),
        $stable(carry_reg), "remainder carry changed outside a scaled event")

endmodule
